### rtl/core/lftm_pkg.sv
// Package for the layered tile flag map.
// Holds operation codes, register indexes, default sizes and the
// controller/datapath command and status types. No dependencies.
package lftm_pkg;

  localparam int unsigned DefMaxLayers  = 4;
  localparam int unsigned DefMaxColumns = 64;
  localparam int unsigned DefMaxRows    = 64;

  // Tile word: sprite, atlas column, atlas row, flags
  localparam int unsigned SpriteW = 11;
  localparam int unsigned TileW   = SpriteW + 8 + 8 + 8;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] CFG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_LAYERS     = 2'd2;

  localparam logic [6:0] RST_MAP_WIDTH  = 7'd10;
  localparam logic [6:0] RST_MAP_HEIGHT = 7'd10;
  localparam logic [2:0] RST_LAYERS     = 3'd0;

  localparam logic [7:0] COLLIDE_MASK = 8'h01;

  typedef struct packed {
    logic clear;   // clearing pass: write zero at the sweep address
    logic accept;  // transaction taken from the input channel
    logic load;    // load the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;  // sweep address is at the final entry
  } dp_status_t;

endpackage

### rtl/core/lftm_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
module lftm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/lftm_ctrl.sv
// Controller for the layered tile flag map: clearing pass, accept, respond.
// Depends on lftm_pkg.
module lftm_ctrl
  import lftm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_RESP  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        // RAM data is valid now; wait only for the result register
        if (out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/core/lftm_datapath.sv
// Datapath: configuration registers, bounds and slot arithmetic, layer banks,
// clearing sweep and result register. Depends on lftm_pkg and lftm_ram.
module lftm_datapath
  import lftm_pkg::*;
#(
  parameter int unsigned MaxLayers  = DefMaxLayers,
  parameter int unsigned MaxColumns = DefMaxColumns,
  parameter int unsigned MaxRows    = DefMaxRows
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ctrl_cmd_t                 cmd_i,
  output dp_status_t                status_o,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_index_i,
  input  logic [6:0]                cfg_data_i,
  input  logic [1:0]                operation_i,
  input  logic signed [3:0]         layer_i,
  input  logic signed [7:0]         column_i,
  input  logic signed [7:0]         row_i,
  input  logic signed [SpriteW-1:0] new_sprite_i,
  input  logic [7:0]                new_atlas_col_i,
  input  logic [7:0]                new_atlas_row_i,
  input  logic [7:0]                new_flags_i,
  output logic                      in_range_o,
  output logic signed [SpriteW-1:0] sprite_read_o,
  output logic [7:0]                atlas_col_read_o,
  output logic [7:0]                atlas_row_read_o,
  output logic [7:0]                flags_read_o,
  output logic                      collides_o
);

  localparam int unsigned Depth = MaxColumns * MaxRows;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned LW    = (MaxLayers > 1) ? $clog2(MaxLayers) : 1;
  localparam logic [AW-1:0] LastAddr = AW'(Depth - 1);

  // Configuration registers
  logic [6:0] map_width_q, map_height_q;
  logic [2:0] layers_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= RST_MAP_WIDTH;
      map_height_q <= RST_MAP_HEIGHT;
      layers_q     <= RST_LAYERS;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MAP_WIDTH:  map_width_q  <= cfg_data_i;
        CFG_MAP_HEIGHT: map_height_q <= cfg_data_i;
        CFG_LAYERS:     layers_q     <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Effective bounds
  logic [7:0] eff_w8, eff_h8;
  logic [4:0] eff_l5;
  logic [6:0] eff_w, eff_h;
  logic [2:0] eff_l;

  always_comb begin
    eff_w8 = ({1'b0, map_width_q} > 8'(MaxColumns)) ? 8'(MaxColumns) : {1'b0, map_width_q};
    eff_h8 = ({1'b0, map_height_q} > 8'(MaxRows)) ? 8'(MaxRows) : {1'b0, map_height_q};
    eff_l5 = ({2'b0, layers_q} > 5'(MaxLayers)) ? 5'(MaxLayers) : {2'b0, layers_q};
    eff_w  = eff_w8[6:0];
    eff_h  = eff_h8[6:0];
    eff_l  = eff_l5[2:0];
  end

  // Bounds and slot from the input ports
  logic          cell_ok, layer_ok;
  logic [13:0]   prod;
  logic [14:0]   slot_sum;
  logic [AW-1:0] slot;
  logic [LW-1:0] lsel;

  always_comb begin
    cell_ok  = !column_i[7] && !row_i[7] &&
               (column_i[6:0] < eff_w) && (row_i[6:0] < eff_h);
    layer_ok = !layer_i[3] && (layer_i[2:0] < eff_l);
    prod     = row_i[6:0] * eff_w;
    slot_sum = {1'b0, prod} + {8'b0, column_i[6:0]};
    slot     = slot_sum[AW-1:0];
    lsel     = LW'({2'b0, layer_i[2:0]});
  end

  // Clearing sweep
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_addr_q <= clr_addr_q + AW'(1);
    end
  end

  assign status_o.clear_last = (clr_addr_q == LastAddr);

  // Layer banks
  logic [TileW-1:0] wdata;
  logic [AW-1:0]    addr;
  logic [TileW-1:0] rdata [MaxLayers];

  assign wdata = cmd_i.clear ? '0 :
                 {new_sprite_i, new_atlas_col_i, new_atlas_row_i, new_flags_i};
  assign addr  = cmd_i.clear ? clr_addr_q : slot;

  for (genvar b = 0; b < MaxLayers; b++) begin : g_bank
    logic bank_wr, bank_rd;

    assign bank_wr = cmd_i.clear ||
                     (cmd_i.accept && cell_ok && layer_ok &&
                      operation_i == OP_WRITE && lsel == LW'(b));
    assign bank_rd = cmd_i.accept && cell_ok &&
                     (operation_i == OP_READ || operation_i == OP_QUERY);

    lftm_ram #(
      .Width(TileW),
      .Depth(Depth)
    ) u_ram (
      .clk_i  (clk_i),
      .en_i   (bank_wr || bank_rd),
      .we_i   (bank_wr),
      .addr_i (addr),
      .wdata_i(wdata),
      .rdata_o(rdata[b])
    );
  end

  // Transaction held for the response state
  logic [1:0]    op_q;
  logic          cell_ok_q, layer_ok_q;
  logic [LW-1:0] lsel_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q       <= operation_i;
      cell_ok_q  <= cell_ok;
      layer_ok_q <= layer_ok;
      lsel_q     <= lsel;
    end
  end

  // Result formation
  logic [7:0]         or_flags;
  logic [TileW-1:0]   sel_tile;
  logic               res_range;
  logic [SpriteW-1:0] res_sprite;
  logic [7:0]         res_acol, res_arow, res_flags;

  always_comb begin
    or_flags = '0;
    for (int unsigned b = 0; b < MaxLayers; b++) begin
      if (5'(b) < {2'b0, eff_l}) begin
        or_flags = or_flags | rdata[b][7:0];
      end
    end
  end

  assign sel_tile = rdata[lsel_q];

  always_comb begin
    res_range  = 1'b0;
    res_sprite = '0;
    res_acol   = '0;
    res_arow   = '0;
    res_flags  = '0;
    unique case (op_q)
      OP_WRITE: res_range = cell_ok_q && layer_ok_q;
      OP_READ: begin
        if (cell_ok_q && layer_ok_q) begin
          res_range = 1'b1;
          {res_sprite, res_acol, res_arow, res_flags} = sel_tile;
        end
      end
      OP_QUERY: begin
        if (cell_ok_q) begin
          res_range = 1'b1;
          res_flags = or_flags;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_range_o       <= res_range;
      sprite_read_o    <= res_sprite;
      atlas_col_read_o <= res_acol;
      atlas_row_read_o <= res_arow;
      flags_read_o     <= res_flags;
      collides_o       <= |(res_flags & COLLIDE_MASK);
    end
  end

endmodule

### rtl/core/layered_tile_flag_map.sv
// Top level of the layered tile flag map.
// Depends on lftm_pkg, lftm_ctrl, lftm_datapath (and lftm_ram below it).
//
//  channel   direction  handshake              payload
//  in        sink       in_valid_i/in_stall_o  operation, layer, column, row, new_*
//  out       source     out_valid_o/out_stall_i in_range, *_read, collides
//  cfg       sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// On accept the bank access is issued (one single-port RAM per layer, all at
// the same slot); from the response state the result register is loaded once
// it is free. The next transaction is accepted while the result waits; a
// stalled result holds the controller in its response state.
// After reset a clearing pass zeroes all MaxColumns*MaxRows entries (4096 at
// default sizes) of every bank, with in_stall_o high; cfg writes always taken.
module layered_tile_flag_map
  import lftm_pkg::*;
#(
  parameter int unsigned MaxLayers  = DefMaxLayers,
  parameter int unsigned MaxColumns = DefMaxColumns,
  parameter int unsigned MaxRows    = DefMaxRows
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [1:0]                cfg_index_i,
  input  logic [6:0]                cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                operation_i,
  input  logic signed [3:0]         layer_i,
  input  logic signed [7:0]         column_i,
  input  logic signed [7:0]         row_i,
  input  logic signed [SpriteW-1:0] new_sprite_i,
  input  logic [7:0]                new_atlas_col_i,
  input  logic [7:0]                new_atlas_row_i,
  input  logic [7:0]                new_flags_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      in_range_o,
  output logic signed [SpriteW-1:0] sprite_read_o,
  output logic [7:0]                atlas_col_read_o,
  output logic [7:0]                atlas_row_read_o,
  output logic [7:0]                flags_read_o,
  output logic                      collides_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  lftm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lftm_datapath #(
    .MaxLayers (MaxLayers),
    .MaxColumns(MaxColumns),
    .MaxRows   (MaxRows)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .operation_i     (operation_i),
    .layer_i         (layer_i),
    .column_i        (column_i),
    .row_i           (row_i),
    .new_sprite_i    (new_sprite_i),
    .new_atlas_col_i (new_atlas_col_i),
    .new_atlas_row_i (new_atlas_row_i),
    .new_flags_i     (new_flags_i),
    .in_range_o      (in_range_o),
    .sprite_read_o   (sprite_read_o),
    .atlas_col_read_o(atlas_col_read_o),
    .atlas_row_read_o(atlas_row_read_o),
    .flags_read_o    (flags_read_o),
    .collides_o      (collides_o)
  );

endmodule
